// File: sv/bhkt_pkg.sv
// ----------------------------------------------------------------------------
// bhkt_pkg: shared types and constants for the bucketed hash key table
// Bucket geometry, key and row types, request and status codes.
// ----------------------------------------------------------------------------
package bhkt_pkg;

    localparam int BUCKETS  = 16;   // power of two: bucket is the low key bits
    localparam int WAYS     = 4;
    localparam int KEY_W    = 31;
    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int FILL_W   = $clog2(WAYS + 1);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [KEY_W-1:0]              key_t;
    typedef logic [BUCKET_W-1:0]           bucket_t;
    typedef logic [FILL_W-1:0]             fill_t;
    typedef logic [WAYS-1:0][KEY_W-1:0]    row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Update decision for one bucket row
    typedef struct packed {
        logic    wr_en;
        fill_t   fill_next;
        status_t status;
    } upd_t;

    function automatic bucket_t bucket_of(key_t key);
        return key[BUCKET_W-1:0];
    endfunction

endpackage

// File: sv/bhkt_ram.sv
// ----------------------------------------------------------------------------
// bhkt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. A read of the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module bhkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/bhkt_row_update.sv
// ----------------------------------------------------------------------------
// bhkt_row_update: bucket row read-modify-write logic
// Matches the key against the occupied ways, appends on insert, removes the
// first match on delete with the later ways moved down, and picks the status.
// ----------------------------------------------------------------------------
module bhkt_row_update (
    input  bhkt_pkg::req_t  req,
    input  bhkt_pkg::key_t  key,
    input  bhkt_pkg::row_t  row,
    input  bhkt_pkg::fill_t fill,
    output bhkt_pkg::row_t  row_next,
    output bhkt_pkg::upd_t  upd
);

    logic [bhkt_pkg::WAYS-1:0]  match;
    logic                       found;
    logic [bhkt_pkg::WAY_W-1:0] hit_way;
    logic                       full;

    always_comb begin
        match   = '0;
        found   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < bhkt_pkg::WAYS; w++) begin
            match[w] = (bhkt_pkg::fill_t'(w) < fill) && (row[w] == key);
        end
        // first matching way wins
        for (int w = bhkt_pkg::WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                found   = 1'b1;
                hit_way = bhkt_pkg::WAY_W'(w);
            end
        end
    end

    assign full = (fill >= bhkt_pkg::fill_t'(bhkt_pkg::WAYS));

    always_comb begin
        row_next      = row;
        upd.wr_en     = 1'b0;
        upd.fill_next = fill;
        upd.status    = bhkt_pkg::ST_NOT_FOUND;
        case (req)
            bhkt_pkg::REQ_INSERT: begin
                if (full) begin
                    upd.status = bhkt_pkg::ST_FULL;
                end else begin
                    for (int w = 0; w < bhkt_pkg::WAYS; w++) begin
                        if (bhkt_pkg::fill_t'(w) == fill) begin
                            row_next[w] = key;
                        end
                    end
                    upd.wr_en     = 1'b1;
                    upd.fill_next = fill + bhkt_pkg::fill_t'(1);
                    upd.status    = bhkt_pkg::ST_INSERTED;
                end
            end
            bhkt_pkg::REQ_DELETE: begin
                if (found) begin
                    for (int w = 0; w < bhkt_pkg::WAYS - 1; w++) begin
                        if (bhkt_pkg::WAY_W'(w) >= hit_way) begin
                            row_next[w] = row[w+1];
                        end
                    end
                    upd.wr_en     = 1'b1;
                    upd.fill_next = fill - bhkt_pkg::fill_t'(1);
                    upd.status    = bhkt_pkg::ST_DELETED;
                end
            end
            default: begin
                // search, and the unused code decoded as a search
                upd.status = found ? bhkt_pkg::ST_FOUND : bhkt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

endmodule

// File: sv/bucketed_hash_key_table_core.sv
// ----------------------------------------------------------------------------
// bucketed_hash_key_table_core: hash key table with fixed-way buckets
// Usage:
//   s_ channel carries one request (insert, delete or search of a key);
//   m_ channel returns one status per request, in request order.
//   Key bucket is the key modulo BUCKETS; each bucket holds up to WAYS keys
//   kept in insertion order, stored as one RAM row per bucket.
// Path: the RAM row read runs alongside the request register, then the row
//   update is registered into the output register.
// Throughput: one request per cycle unless the output stalls. The row read
//   and write-back go through a single dual-port RAM; a request to the
//   bucket just written takes its row from a forwarding register, so there
//   is no interlock.
// Reset: all fill counts clear, so every bucket reads empty; RAM contents are
//   not cleared and need no clearing pass. The block is ready right away.
// Stall: while m_ready is low the output holds, the update stage holds its
//   request and s_ready drops once both are occupied.
// ----------------------------------------------------------------------------
module bucketed_hash_key_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [30:0] s_key_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status
);

    // update stage
    logic               s1_valid_reg;
    bhkt_pkg::req_t     s1_req_reg;
    bhkt_pkg::key_t     s1_key_reg;
    bhkt_pkg::bucket_t  s1_bucket;
    logic               s1_fire;
    logic               s_accept;

    // bucket fill counts
    bhkt_pkg::fill_t    fill_reg [bhkt_pkg::BUCKETS];
    bhkt_pkg::fill_t    s1_fill;

    // row storage and forwarding of the last written row
    bhkt_pkg::row_t     ram_rdata;
    bhkt_pkg::row_t     s1_row;
    bhkt_pkg::row_t     row_next;
    bhkt_pkg::upd_t     upd;
    logic               fwd_valid_reg;
    bhkt_pkg::bucket_t  fwd_bucket_reg;
    bhkt_pkg::row_t     fwd_row_reg;

    // output register
    logic               m_valid_reg;
    bhkt_pkg::status_t  m_status_reg;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    assign s1_bucket = bhkt_pkg::bucket_of(s1_key_reg);
    assign s1_fill   = fill_reg[s1_bucket];
    // fwd register always holds the newest write, so a bucket match is current
    assign s1_row    = (fwd_valid_reg && (fwd_bucket_reg == s1_bucket)) ?
                       fwd_row_reg : ram_rdata;

    bhkt_ram #(
        .WIDTH (bhkt_pkg::ROW_W),
        .DEPTH (bhkt_pkg::BUCKETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (s1_fire && upd.wr_en),
        .waddr (s1_bucket),
        .wdata (row_next),
        .re    (s_accept),
        .raddr (bhkt_pkg::bucket_of(s_key_value)),
        .rdata (ram_rdata)
    );

    bhkt_row_update u_row_update (
        .req      (s1_req_reg),
        .key      (s1_key_reg),
        .row      (s1_row),
        .fill     (s1_fill),
        .row_next (row_next),
        .upd      (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int b = 0; b < bhkt_pkg::BUCKETS; b++) begin
                fill_reg[b] <= '0;
            end
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (s1_fire && upd.wr_en) begin
                fill_reg[s1_bucket] <= upd.fill_next;
                fwd_valid_reg       <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg <= bhkt_pkg::req_t'(s_req_type);
            s1_key_reg <= s_key_value;
        end
        if (s1_fire) begin
            m_status_reg <= upd.status;
        end
        if (s1_fire && upd.wr_en) begin
            fwd_bucket_reg <= s1_bucket;
            fwd_row_reg    <= row_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // An insert into a full bucket must report full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_req_reg == bhkt_pkg::REQ_INSERT &&
         s1_fill == bhkt_pkg::fill_t'(bhkt_pkg::WAYS))
        |=> (m_status_reg == bhkt_pkg::ST_FULL))
        else $error("insert into full bucket not reported full");

    // Fill counts never exceed the way count
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (s1_fill <= bhkt_pkg::fill_t'(bhkt_pkg::WAYS)))
        else $error("bucket fill count out of range");

    // Input is only held off when both stages are occupied and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("s_ready low without downstream stall");

    // A completed update always leaves a transaction in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire |=> m_valid_reg)
        else $error("update stage fired without output");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: bucketed hash key table core
// A directed table, then random insert, delete, search and unused traffic,
// mostly over a small pool of colliding keys. Every status is checked in order
// against a typed value or a behavioral table copy; both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import bhkt_pkg::*;

    localparam int RANDOM_ITEMS = 730;
    localparam int POOL_N       = 24;
    localparam int STALL_AT     = 200;
    localparam int STALL_CYCLES = 100;
    localparam key_t KEY_TOP    = 31'h7FFF_FFFF;

    // status is typed in for FIXED rows; CALC rows take the predicted status
    localparam logic FIXED = 1'b1;
    localparam logic CALC  = 1'b0;

    typedef struct packed {
        req_t    req;
        key_t    key;
        logic    fixed;
        status_t status;
    } dir_row_t;

    localparam int DIR_N = 24;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{REQ_SEARCH, 31'd0,         FIXED, ST_NOT_FOUND},
        '{REQ_DELETE, 31'd0,         FIXED, ST_NOT_FOUND},
        '{REQ_INSERT, 31'd0,         FIXED, ST_INSERTED},
        '{REQ_SEARCH, 31'd0,         FIXED, ST_FOUND},
        '{REQ_INSERT, KEY_TOP,       FIXED, ST_INSERTED},
        '{REQ_SEARCH, KEY_TOP,       FIXED, ST_FOUND},
        '{REQ_UNUSED, KEY_TOP,       FIXED, ST_FOUND},
        '{REQ_UNUSED, 31'h7FFF_FFEF, FIXED, ST_NOT_FOUND},
        '{REQ_INSERT, 31'd5,         FIXED, ST_INSERTED},
        '{REQ_INSERT, 31'd21,        FIXED, ST_INSERTED},
        '{REQ_INSERT, 31'd5,         FIXED, ST_INSERTED},
        '{REQ_INSERT, 31'd37,        FIXED, ST_INSERTED},
        '{REQ_INSERT, 31'd53,        FIXED, ST_FULL},
        '{REQ_DELETE, 31'd5,         FIXED, ST_DELETED},
        '{REQ_SEARCH, 31'd5,         FIXED, ST_FOUND},
        '{REQ_INSERT, 31'd53,        CALC,  ST_INSERTED},
        '{REQ_DELETE, 31'd21,        CALC,  ST_INSERTED},
        '{REQ_DELETE, 31'd21,        FIXED, ST_NOT_FOUND},
        '{REQ_SEARCH, 31'd53,        CALC,  ST_INSERTED},
        '{REQ_DELETE, 31'd5,         CALC,  ST_INSERTED},
        '{REQ_SEARCH, 31'd5,         FIXED, ST_NOT_FOUND},
        '{REQ_DELETE, KEY_TOP,       FIXED, ST_DELETED},
        '{REQ_SEARCH, KEY_TOP,       FIXED, ST_NOT_FOUND},
        '{REQ_INSERT, 31'h2AAA_AAAA, CALC,  ST_INSERTED}
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic [1:0]  s_req_type  = 2'd0;
    logic [30:0] s_key_value = 31'd0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_status;

    key_t    table_keys [BUCKETS][WAYS];
    int      table_fill [BUCKETS];
    key_t    key_pool [POOL_N];
    status_t status_q [$];
    bit      failed       = 1'b0;
    bit      idle_on      = 1'b1;
    int      results_seen = 0;

    bucketed_hash_key_table_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_key_value (s_key_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one request to the table copy and return its status
    function automatic status_t apply_request(req_t req, key_t key);
        int      b;
        int      n;
        int      hit;
        status_t st;
        b   = int'(key % BUCKETS);
        n   = table_fill[b];
        hit = -1;
        for (int w = 0; w < n; w++) begin
            if (hit < 0 && table_keys[b][w] == key) hit = w;
        end
        case (req)
            REQ_INSERT: begin
                if (n >= WAYS) begin
                    st = ST_FULL;
                end else begin
                    table_keys[b][n] = key;
                    table_fill[b]    = n + 1;
                    st               = ST_INSERTED;
                end
            end
            REQ_DELETE: begin
                if (hit < 0) begin
                    st = ST_NOT_FOUND;
                end else begin
                    for (int w = hit; w < n - 1; w++) table_keys[b][w] = table_keys[b][w + 1];
                    table_fill[b] = n - 1;
                    st            = ST_DELETED;
                end
            end
            // unused code decodes as a search
            default: st = (hit < 0) ? ST_NOT_FOUND : ST_FOUND;
        endcase
        return st;
    endfunction

    task automatic send_request(req_t req, key_t key, logic fixed, status_t fixed_status);
        int      gap;
        status_t predicted;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_key_value <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_request(req, key);
        status_q.push_back(fixed ? fixed_status : predicted);
    endtask

    // Phases lean toward filling buckets, churning, then draining them
    task automatic random_request(int idx);
        int   phase;
        int   pick;
        int   ins_lim;
        int   del_lim;
        req_t req;
        key_t key;
        phase   = (idx / 120) % 3;
        pick    = $urandom_range(0, 99);
        ins_lim = (phase == 0) ? 55 : (phase == 1) ? 35 : 20;
        del_lim = (phase == 1) ? 65 : 75;
        if (pick < ins_lim)      req = REQ_INSERT;
        else if (pick < del_lim) req = REQ_DELETE;
        else if (pick < 95)      req = REQ_SEARCH;
        else                     req = REQ_UNUSED;
        if ($urandom_range(0, 4) == 0) key = key_t'($urandom);
        else                           key = key_pool[$urandom_range(0, POOL_N - 1)];
        send_request(req, key, CALC, ST_INSERTED);
    endtask

    initial begin
        int unsigned raw;
        int unsigned b;
        // most pool keys collide in a handful of buckets
        for (int i = 0; i < POOL_N; i++) begin
            raw = $urandom & 32'h7FFF_FFFF;
            b   = (i < 18) ? $urandom_range(0, 5) : $urandom_range(0, BUCKETS - 1);
            key_pool[i] = key_t'(raw - (raw % BUCKETS) + b);
        end
        for (int i = 0; i < BUCKETS; i++) table_fill[i] = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            send_request(DIR_ROWS[i].req, DIR_ROWS[i].key, DIR_ROWS[i].fixed,
                         DIR_ROWS[i].status);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            random_request(i);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (status_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (!failed) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: random back-pressure plus one long hold to fill the pipe
    initial begin
        int      hold;
        status_t want;
        wait (aresetn === 1'b1);
        forever begin
            hold = idle_on ? $urandom_range(0, 4) : 0;
            if (results_seen == STALL_AT) hold = STALL_CYCLES;
            repeat (hold) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_seen++;
            if (status_q.size() == 0) begin
                $error("status: no transaction outstanding, got %0d", m_status);
                failed = 1'b1;
            end else begin
                want = status_q.pop_front();
                if (m_status !== 3'(want)) begin
                    $error("status: expected %0d, actual %0d", want, m_status);
                    failed = 1'b1;
                end
            end
        end
    end

endmodule
